// ===== hdl/frb_pkg.sv =====
// ----------------------------------------------------------------------------
// frb_pkg
// Shared constants, types and helpers for the framed byte receiver.
// ----------------------------------------------------------------------------
package frb_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int LEN_W        = 9;
  localparam int STATUS_W     = 3;
  localparam int MARK_BYTES   = 4;

  localparam logic [31:0] RESET_PREAMBLE  = 32'd123456789;
  localparam logic [31:0] RESET_POSTAMBLE = 32'd987654321;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSTAMBLE = 1'b1;

  localparam logic [1:0] MARK_LAST = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_HUNT     = 3'd0,
    ST_PRE      = 3'd1,
    ST_PRE_DONE = 3'd2,
    ST_COLLECT  = 3'd3,
    ST_ACCEPT   = 3'd4,
    ST_REJECT   = 3'd5,
    ST_READ     = 3'd6
  } status_e;

  // marker byte at position pos, most significant byte first
  function automatic logic [7:0] mark_byte(input logic [31:0] word, input logic [1:0] pos);
    return word[{~pos, 3'b000} +: 8];
  endfunction

endpackage

// ===== hdl/frb_ram.sv =====
// ----------------------------------------------------------------------------
// frb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/framed_byte_receiver.sv =====
// ----------------------------------------------------------------------------
// framed_byte_receiver
// Hunts for a 4-byte start marker, stores the frame, watches for a 4-byte
// end marker and checks the big-endian length word at bytes 4 to 7.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o   | action_i, byte_value_i, read_index_i
//  out     | out_valid_o / out_stall_i | status_o, frame_length_o, read_data_o
//  cfg     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
//  One transaction per cycle while in_stall_o is low; its result shows in the cycle after acceptance.
//  Compare, counter update and frame store write happen in the accept cycle;
//  read replies come from the registered read port of the frame store.
//  in_stall_o is high only while a result is held by out_stall_i.
//  Reset clears control state; the frame store is not cleared.
// ----------------------------------------------------------------------------
module framed_byte_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [frb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [7:0]                     byte_value_i,
  input  logic [7:0]                     read_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [frb_pkg::STATUS_W-1:0]   status_o,
  output logic [frb_pkg::LEN_W-1:0]      frame_length_o,
  output logic [7:0]                     read_data_o
);
  import frb_pkg::*;

  logic [31:0]       pre_word_q, post_word_q;
  logic              coll_q, coll_d;
  logic [1:0]        pre_q, pre_d;
  logic [1:0]        post_q, post_d;
  logic [ADDR_W-1:0] wi_q, wi_d;
  logic [31:0]       len_word_q, len_word_d;

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              rd_sel_q;

  logic              in_acc, is_rx, is_rd, rd_ok;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        ram_rdata;
  logic [31:0]       len_sum;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_rx      = in_acc & ~action_i;
  assign is_rd      = in_acc & action_i;
  assign rd_ok      = (32'(read_index_i) < 32'(BUFFER_DEPTH));
  assign len_sum    = 32'(wi_d) + 32'd1;

  always_comb begin
    coll_d     = coll_q;
    pre_d      = pre_q;
    post_d     = post_q;
    wi_d       = wi_q;
    len_word_d = len_word_q;
    status_d   = ST_HUNT;
    len_d      = '0;
    we         = 1'b0;
    waddr      = wi_q;
    if (action_i) begin
      status_d = ST_READ;
    end else if (!coll_q) begin
      if (byte_value_i == mark_byte(pre_word_q, pre_q)) begin
        we    = 1'b1;
        waddr = ADDR_W'(pre_q);
        if (pre_q == MARK_LAST) begin
          pre_d    = 2'd0;
          wi_d     = ADDR_W'(MARK_BYTES - 1);
          coll_d   = 1'b1;
          status_d = ST_PRE_DONE;
        end else begin
          pre_d    = pre_q + 2'd1;
          status_d = ST_PRE;
        end
      end else begin
        pre_d = 2'd0;
      end
    end else begin
      if (wi_q < ADDR_W'(BUFFER_DEPTH - 1)) begin
        wi_d = wi_q + ADDR_W'(1);
      end
      we       = 1'b1;
      waddr    = wi_d;
      status_d = ST_COLLECT;
      for (int l = 0; l < 4; l++) begin
        if (wi_d == ADDR_W'(MARK_BYTES + l)) begin
          len_word_d[(3 - l) * 8 +: 8] = byte_value_i;
        end
      end
      if (byte_value_i == mark_byte(post_word_q, post_q)) begin
        if (post_q == MARK_LAST) begin
          post_d   = 2'd0;
          coll_d   = 1'b0;
          len_d    = LEN_W'(len_sum);
          status_d = (len_word_d == len_sum) ? ST_ACCEPT : ST_REJECT;
        end else begin
          post_d = post_q + 2'd1;
        end
      end else begin
        post_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_word_q  <= RESET_PREAMBLE;
      post_word_q <= RESET_POSTAMBLE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PREAMBLE:  pre_word_q  <= cfg_data_i;
        CFG_POSTAMBLE: post_word_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q <= 1'b0;
      pre_q  <= '0;
      post_q <= '0;
      wi_q   <= '0;
    end else if (is_rx) begin
      coll_q <= coll_d;
      pre_q  <= pre_d;
      post_q <= post_d;
      wi_q   <= wi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_rx) begin
      len_word_q <= len_word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      len_q    <= len_d;
      rd_sel_q <= action_i & rd_ok;
    end
  end

  frb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (is_rx & we),
    .waddr_i (waddr),
    .wdata_i (byte_value_i),
    .re_i    (is_rd),
    .raddr_i (ADDR_W'(read_index_i)),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign frame_length_o = len_q;
  assign read_data_o    = rd_sel_q ? ram_rdata : 8'd0;

`ifndef SYNTHESIS
  a_coll_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    coll_q |-> (wi_q >= ADDR_W'(MARK_BYTES - 1)))
    else $error("write index below marker length while collecting");

  a_hunt_post : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !coll_q |-> (post_q == 2'd0))
    else $error("end marker count nonzero while hunting");

  a_read_reply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_rd |=> (out_valid_q && status_q == ST_READ))
    else $error("read transaction gave no read reply");

  a_frame_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_ACCEPT || status_q == ST_REJECT))
      |-> (len_q >= LEN_W'(2 * MARK_BYTES)))
    else $error("frame ended shorter than two markers");

  a_read_no_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_rd |=> ($stable(coll_q) && $stable(wi_q) && $stable(pre_q)))
    else $error("read transaction changed receive state");
`endif

endmodule

// ===== verif/tb_framed_byte_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_byte_receiver
// Drives framed byte streams (start marker, length word, payload, end marker)
// mixed with noise, broken markers and stored-byte reads through several
// marker settings. A cycle-free predictor computes every reply, and each
// returned transaction is checked field by field while both sides idle at
// random, except under the last marker setting.
// ----------------------------------------------------------------------------
module tb_framed_byte_receiver;
  import frb_pkg::*;

  localparam int HOLD_CYCLES = 80;

  typedef struct {
    status_e          status;
    logic [LEN_W-1:0] length;
    logic [7:0]       data;
  } reply_t;

  class frame_scoreboard;
    logic [31:0] start_mark;
    logic [31:0] end_mark;
    bit          in_frame;
    int unsigned start_hits;
    int unsigned end_hits;
    int unsigned wr_ptr;
    logic [7:0]  frame_mem [BUFFER_DEPTH];
    bit          mem_valid [BUFFER_DEPTH];
    reply_t      replies_q [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned n_accept;
    int unsigned n_reject;
    int unsigned n_read;

    function new();
      start_mark = RESET_PREAMBLE;
      end_mark   = RESET_POSTAMBLE;
      in_frame   = 1'b0;
      start_hits = 0;
      end_hits   = 0;
      wr_ptr     = 0;
      mismatches = 0;
      checked    = 0;
      n_accept   = 0;
      n_reject   = 0;
      n_read     = 0;
      foreach (mem_valid[i]) mem_valid[i] = 1'b0;
    endfunction

    function logic [7:0] octet(input logic [31:0] word, input int unsigned pos);
      return 8'(word >> (8 * (3 - pos)));
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
      case (idx)
        CFG_PREAMBLE:  start_mark = value;
        CFG_POSTAMBLE: end_mark = value;
        default: ;
      endcase
    endfunction

    function void note_transaction(input bit act, input logic [7:0] b,
                                   input logic [7:0] ridx);
      reply_t      r;
      logic [31:0] len_word;
      r.status = ST_HUNT;
      r.length = '0;
      r.data   = '0;
      if (act) begin
        r.status = ST_READ;
        if (ridx < BUFFER_DEPTH) r.data = frame_mem[ridx];
        n_read++;
      end else if (!in_frame) begin
        if (b == octet(start_mark, start_hits)) begin
          frame_mem[start_hits] = b;
          mem_valid[start_hits] = 1'b1;
          start_hits++;
          r.status = ST_PRE;
        end else begin
          start_hits = 0;
        end
        if (start_hits == MARK_BYTES) begin
          start_hits = 0;
          wr_ptr     = MARK_BYTES - 1;
          in_frame   = 1'b1;
          r.status   = ST_PRE_DONE;
        end
      end else begin
        if (wr_ptr < BUFFER_DEPTH - 1) wr_ptr++;
        frame_mem[wr_ptr] = b;
        mem_valid[wr_ptr] = 1'b1;
        r.status = ST_COLLECT;
        if (b != octet(end_mark, end_hits)) end_hits = 0;
        else end_hits++;
        if (end_hits == MARK_BYTES) begin
          len_word = {frame_mem[4], frame_mem[5], frame_mem[6], frame_mem[7]};
          r.length = LEN_W'(wr_ptr + 1);
          if (len_word == wr_ptr + 1) begin
            r.status = ST_ACCEPT;
            n_accept++;
          end else begin
            r.status = ST_REJECT;
            n_reject++;
          end
          end_hits = 0;
          in_frame = 1'b0;
        end
      end
      replies_q.push_back(r);
    endfunction

    function void check_reply(input logic [STATUS_W-1:0] st, input logic [LEN_W-1:0] len,
                              input logic [7:0] data);
      reply_t r;
      if (replies_q.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none pending: status %0d length %0d data %02h",
                 $time, st, len, data);
        return;
      end
      r = replies_q.pop_front();
      checked++;
      if (st !== r.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, r.status, st);
      end
      if (len !== r.length) begin
        mismatches++;
        $display("%0t: frame_length expected %0d actual %0d", $time, r.length, len);
      end
      if (data !== r.data) begin
        mismatches++;
        $display("%0t: read_data expected %02h actual %02h", $time, r.data, data);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_PREAMBLE;
  logic [31:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 action_i = 1'b0;
  logic [7:0]           byte_value_i = '0;
  logic [7:0]           read_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [LEN_W-1:0]     frame_length_o;
  logic [7:0]           read_data_o;

  frame_scoreboard sb;
  bit              no_idle = 1'b0;
  bit              hold_req = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     marker_settings = 1;

  framed_byte_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .byte_value_i   (byte_value_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .frame_length_o (frame_length_o),
    .read_data_o    (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_reply(status_o, frame_length_o, read_data_o);
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (no_idle) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input bit act, input logic [7:0] b, input logic [7:0] ridx);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    byte_value_i <= b;
    read_index_i <= ridx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_transaction(act, b, ridx);
    items_sent++;
  endtask

  task automatic send_read();
    logic [7:0]  idx;
    int unsigned tries;
    idx = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom);
    for (tries = 0; tries < 16 && !sb.mem_valid[idx]; tries++) idx = 8'($urandom);
    if (!sb.mem_valid[idx]) idx = 8'd0;
    if (sb.mem_valid[idx]) send_item(1'b1, 8'($urandom), idx);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 7) == 0) send_read();
    send_item(1'b0, b, 8'($urandom));
  endtask

  task automatic send_end_mark();
    int unsigned k;
    if (!sb.in_frame) return;
    if (sb.end_hits != 0) send_byte(~sb.octet(sb.end_mark, sb.end_hits));
    for (k = 0; k < MARK_BYTES; k++) send_byte(sb.octet(sb.end_mark, k));
  endtask

  task automatic send_start_mark();
    int unsigned k;
    if (sb.in_frame) send_end_mark();
    if (sb.start_hits != 0) send_byte(~sb.octet(sb.start_mark, sb.start_hits));
    for (k = 0; k < MARK_BYTES; k++) send_byte(sb.octet(sb.start_mark, k));
  endtask

  task automatic send_frame(input bit go_long);
    int unsigned n;
    int unsigned k;
    int unsigned cut;
    int unsigned total;
    logic [31:0] len_word;
    n = (go_long || $urandom_range(0, 24) == 0) ? $urandom_range(240, 300)
                                                : $urandom_range(0, 24);
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, 3);
      for (k = 0; k < cut; k++) send_byte(sb.octet(sb.start_mark, k));
      send_byte(8'($urandom));
    end
    send_start_mark();
    total = (n + 12 > BUFFER_DEPTH) ? BUFFER_DEPTH : n + 12;
    len_word = total;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: len_word = $urandom;
        1: len_word = total + 1;
        default: len_word = total - 1;
      endcase
    end
    for (k = 0; k < MARK_BYTES; k++) send_byte(sb.octet(len_word, k));
    for (k = 0; k < n; k++) send_byte(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, 3);
      for (k = 0; k < cut; k++) send_byte(sb.octet(sb.end_mark, k));
    end
    send_end_mark();
  endtask

  task automatic run_frames(input int unsigned count);
    int unsigned stop;
    stop = items_sent + count;
    while (items_sent < stop) send_frame(1'b0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.replies_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic set_markers(input logic [31:0] start_word, input logic [31:0] end_word);
    settle();
    write_reg(CFG_PREAMBLE, start_word);
    write_reg(CFG_POSTAMBLE, end_word);
    marker_settings++;
  endtask

  initial begin
    int unsigned k;
    rst_ni <= 1'b0;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes while hunting, then a start marker broken after two bytes
    send_item(1'b0, 8'h00, 8'h00);
    send_item(1'b0, 8'hFF, 8'hFF);
    send_item(1'b0, sb.octet(sb.start_mark, 0), 8'h00);
    send_item(1'b0, sb.octet(sb.start_mark, 1), 8'h00);
    send_item(1'b0, sb.octet(sb.start_mark, 0), 8'h00);
    for (k = 0; k < MARK_BYTES; k++) send_item(1'b0, sb.octet(sb.start_mark, k), 8'h00);
    for (k = 0; k < MARK_BYTES; k++) send_item(1'b0, sb.octet(32'd15, k), 8'h00);
    send_item(1'b1, 8'hA5, 8'd0);
    // end marker broken after two bytes, then the full end marker
    send_item(1'b0, sb.octet(sb.end_mark, 0), 8'h00);
    send_item(1'b0, sb.octet(sb.end_mark, 1), 8'h00);
    send_item(1'b0, 8'h00, 8'h00);
    for (k = 0; k < MARK_BYTES; k++) send_item(1'b0, sb.octet(sb.end_mark, k), 8'h00);
    send_item(1'b1, 8'h5A, 8'd14);

    send_frame(1'b1);
    run_frames(80);

    set_markers(32'h0000_0000, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    run_frames(110);

    set_markers(32'hFFFF_FFFF, 32'h0000_0000);
    run_frames(70);

    set_markers($urandom, $urandom);
    send_frame(1'b1);
    run_frames(60);

    set_markers($urandom, $urandom);
    no_idle = 1'b1;
    run_frames(80);

    settle();
    $display("run covered %0d transactions, %0d replies checked, %0d marker settings",
             items_sent, sb.checked, marker_settings);
    $display("frames accepted %0d, rejected %0d, stored-byte reads %0d",
             sb.n_accept, sb.n_reject, sb.n_read);
    if (sb.mismatches == 0 && sb.replies_q.size() == 0) begin
      $display("tb_framed_byte_receiver: PASS");
    end else begin
      $display("tb_framed_byte_receiver: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("tb_framed_byte_receiver: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/frb_pkg.sv
hdl/frb_ram.sv
hdl/framed_byte_receiver.sv
verif/tb_framed_byte_receiver.sv
